// ----- rtl/core/fctt_pkg.sv -----
// fctt_pkg: types and constants for the flight countdown / teach timer core.
// No dependencies; imported by flight_countdown_teach_timer_core.
`default_nettype none

package fctt_pkg;

	// Operating modes
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_COUNT = 2'd1,
		MODE_TEACH = 2'd2,
		MODE_STORE = 2'd3
	} mode_t;

	// Button event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_MAIN  = 2'd1;
	localparam logic [1:0] EV_TEACH = 2'd2;
	localparam logic [1:0] EV_OTHER = 2'd3;

	// Flight timer kept as whole minutes plus milliseconds within the minute
	localparam logic [15:0] MS_PER_MIN  = 16'd60000;
	// 20-bit saturation point 0xFFFFF = 17 min + 28575 ms
	localparam logic [4:0]  FLT_SAT_MIN = 5'd17;
	localparam logic [15:0] FLT_SAT_SUB = 16'd28575;

	localparam logic [9:0]  END_MS_MAX       = 10'h3FF;
	localparam logic [12:0] TEACH_MS_MAX     = 13'h1FFF;
	localparam logic [9:0]  END_FLASH_PERIOD = 10'd600;
	localparam logic [12:0] TEACH_BASE_MS    = 13'd1000;
	localparam logic [12:0] TEACH_STEP_MS    = 13'd400;
	localparam logic [3:0]  TEACH_TOP_MIN    = 4'd10;

	localparam logic [8:0]  FLASH_LONG_MS  = 9'd300;
	localparam logic [8:0]  FLASH_SHORT_MS = 9'd200;

	typedef struct packed {
		logic [1:0] button_event;
		logic       teach_active;
		logic [9:0] ms_elapsed;
	} call_t;

	typedef struct packed {
		logic       time_up;
		logic       flash_valid;
		logic [3:0] flash_count;
		logic [8:0] flash_on_ms;
		logic [8:0] flash_off_ms;
		logic       store_valid;
		logic [3:0] store_minutes;
	} result_t;

	// Teach dwell for a given minute value: 1000 + 400 * minutes
	function automatic logic [12:0] teach_dwell(input logic [3:0] minutes);
		return TEACH_BASE_MS + 13'(minutes) * TEACH_STEP_MS;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/flight_countdown_teach_timer_core.sv -----
// flight_countdown_teach_timer_core: countdown / teach timer, one control call per transaction.
// Depends on fctt_pkg (types, mode codes, timing constants).
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+-------------------------
//  call    | call_valid, call_ready, call     | in        | call_t: event, lock, ms
//  result  | result_valid, result_ready, result| out      | result_t: up, flash, store
//  cfg     | cfg_valid, cfg_ready, cfg_data   | in        | stored flight minutes
//
// One call per clock while results are taken: a call waits in the input register (s1),
// then the mode logic and saturating counters update the state and load the
// result register in a single pass. The result is valid once s1 has moved into that register.
// A stalled result holds the pipeline; call_ready stays high while s1 is free
// or draining. Reset (arst_n low) clears mode, counters and flight minutes.
// cfg is always ready and reloads the flight minutes directly.
`default_nettype none

module flight_countdown_teach_timer_core
	import fctt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,

	input  wire logic       call_valid,
	output logic            call_ready,
	input  wire call_t      call,

	output logic            result_valid,
	input  wire logic       result_ready,
	output result_t         result,

	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [3:0] cfg_data
);

	// ---------------------------------------------------------------
	// Handshake and input register
	// ---------------------------------------------------------------
	logic  call_vld_s1;
	call_t call_s1;
	logic  advance;

	// s1 moves into the result register when that is empty or being taken
	assign advance    = call_vld_s1 && (!result_valid || result_ready);
	assign call_ready = !call_vld_s1 || advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			call_vld_s1 <= 1'b0;
		end else if (call_ready) begin
			call_vld_s1 <= call_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (call_valid && call_ready) begin
			call_s1 <= call;
		end
	end

	// ---------------------------------------------------------------
	// Block state
	// ---------------------------------------------------------------
	mode_t       mode_q,      mode_d;
	logic [3:0]  fmin_q,      fmin_d;      // flight minutes
	logic [4:0]  remain_q,    remain_d;    // last flashed remaining minutes
	logic [4:0]  flt_min_q,   flt_min_d;   // flight timer, whole minutes
	logic [15:0] flt_sub_q,   flt_sub_d;   // flight timer, ms within minute
	logic [9:0]  end_ms_q,    end_ms_d;
	logic [12:0] teach_ms_q,  teach_ms_d;
	result_t     res_d;

	// Counter updates with saturation, done ahead of the mode logic
	logic [16:0] flt_sum;
	logic [4:0]  flt_min_a;
	logic [15:0] flt_sub_a;
	logic [10:0] end_sum;
	logic [9:0]  end_ms_a;
	logic [13:0] teach_sum;
	logic [12:0] teach_ms_a;
	mode_t       mode_a;
	logic [3:0]  fmin_a;
	logic [3:0]  left;

	always_comb begin
		flt_sum = 17'(flt_sub_q) + 17'(call_s1.ms_elapsed);
		if (flt_sum >= 17'(MS_PER_MIN)) begin
			flt_min_a = flt_min_q + 5'd1;
			flt_sub_a = 16'(flt_sum - 17'(MS_PER_MIN));
		end else begin
			flt_min_a = flt_min_q;
			flt_sub_a = flt_sum[15:0];
		end
		if (flt_min_a > FLT_SAT_MIN ||
				(flt_min_a == FLT_SAT_MIN && flt_sub_a > FLT_SAT_SUB)) begin
			flt_min_a = FLT_SAT_MIN;
			flt_sub_a = FLT_SAT_SUB;
		end

		end_sum  = 11'(end_ms_q) + 11'(call_s1.ms_elapsed);
		end_ms_a = end_sum[10] ? END_MS_MAX : end_sum[9:0];

		teach_sum  = 14'(teach_ms_q) + 14'(call_s1.ms_elapsed);
		teach_ms_a = teach_sum[13] ? TEACH_MS_MAX : teach_sum[12:0];

		// Menu presses override the mode before the mode step
		mode_a = mode_q;
		fmin_a = fmin_q;
		if (call_s1.button_event == EV_TEACH) begin
			mode_a     = MODE_TEACH;
			teach_ms_a = '0;
			fmin_a     = '0;
		end else if (call_s1.button_event == EV_OTHER) begin
			mode_a = MODE_IDLE;
		end

		mode_d     = mode_a;
		fmin_d     = fmin_a;
		remain_d   = remain_q;
		flt_min_d  = flt_min_a;
		flt_sub_d  = flt_sub_a;
		end_ms_d   = end_ms_a;
		teach_ms_d = teach_ms_a;
		res_d      = '0;
		left       = fmin_a - flt_min_a[3:0];

		case (mode_a)
			MODE_IDLE: begin
				if (call_s1.button_event == EV_MAIN && !call_s1.teach_active) begin
					remain_d  = 5'(fmin_a) + 5'd1;
					mode_d    = MODE_COUNT;
					flt_min_d = '0;
					flt_sub_d = '0;
					end_ms_d  = '0;
				end
			end
			MODE_COUNT: begin
				if (call_s1.button_event == EV_MAIN) begin
					mode_d = MODE_IDLE;
				end else if (flt_min_a < 5'(fmin_a)) begin
					// New whole-minute count: flash it once
					if (remain_q != 5'(left)) begin
						remain_d           = 5'(left);
						res_d.flash_valid  = 1'b1;
						res_d.flash_count  = left;
						res_d.flash_on_ms  = FLASH_LONG_MS;
						res_d.flash_off_ms = FLASH_LONG_MS;
					end
				end else begin
					res_d.time_up = 1'b1;
					if (end_ms_a >= END_FLASH_PERIOD) begin
						end_ms_d           = '0;
						res_d.flash_valid  = 1'b1;
						res_d.flash_count  = 4'd1;
						res_d.flash_on_ms  = FLASH_SHORT_MS;
						res_d.flash_off_ms = FLASH_SHORT_MS;
					end
				end
			end
			MODE_TEACH: begin
				if (call_s1.button_event == EV_MAIN) begin
					mode_d = MODE_STORE;
				end else if (teach_ms_a >= teach_dwell(fmin_a)) begin
					teach_ms_d         = '0;
					fmin_d             = (fmin_a < TEACH_TOP_MIN) ? fmin_a + 4'd1 : 4'd1;
					res_d.flash_valid  = 1'b1;
					res_d.flash_count  = fmin_d;
					res_d.flash_on_ms  = FLASH_SHORT_MS;
					res_d.flash_off_ms = FLASH_SHORT_MS;
				end
			end
			default: begin
				res_d.store_valid   = 1'b1;
				res_d.store_minutes = fmin_a;
				mode_d              = MODE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			fmin_q     <= '0;
			remain_q   <= '0;
			flt_min_q  <= '0;
			flt_sub_q  <= '0;
			end_ms_q   <= '0;
			teach_ms_q <= '0;
		end else begin
			if (advance) begin
				mode_q     <= mode_d;
				fmin_q     <= fmin_d;
				remain_q   <= remain_d;
				flt_min_q  <= flt_min_d;
				flt_sub_q  <= flt_sub_d;
				end_ms_q   <= end_ms_d;
				teach_ms_q <= teach_ms_d;
			end
			// setup read of stored minutes reloads the duration
			if (cfg_valid && cfg_ready) begin
				fmin_q <= cfg_data;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= res_d;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> call_ready)
		else $error("call_ready low with an empty result register");

	a_store_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.store_valid |-> mode_q == MODE_IDLE)
		else $error("store transaction did not leave the block idle");

	a_up_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.time_up |-> mode_q == MODE_COUNT)
		else $error("time_up reported outside countdown");

	a_flight_range: assert property (@(posedge clk) disable iff (!arst_n)
		flt_sub_q < MS_PER_MIN && flt_min_q <= FLT_SAT_MIN &&
		(flt_min_q != FLT_SAT_MIN || flt_sub_q <= FLT_SAT_SUB))
		else $error("flight timer outside its saturating range");

	a_remain_tracks_flash: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.flash_valid && result.flash_on_ms == FLASH_LONG_MS
		|-> remain_q == 5'(result.flash_count))
		else $error("remaining minutes not updated with minute flash");

endmodule

`default_nettype wire

// ----- dv/tb_flight_countdown_teach_timer_core.sv -----
// Self-checking testbench for flight_countdown_teach_timer_core: directed and random control calls.
// A scoreboard class predicts each result transaction and compares it with the block's output.
// Depends on fctt_pkg and the core RTL only.

module tb_flight_countdown_teach_timer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fctt_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000; // far above the slowest correct run
	localparam int unsigned DRAIN_CYCLES  = 6;
	localparam int unsigned RANDOM_CALLS  = 450;
	localparam int unsigned PHASES        = 4;
	localparam logic [19:0] FLIGHT_MS_TOP = 20'hFFFFF;

	// Scoreboard: tracks the timer state, predicts one result per accepted call and
	// checks returned results in order.
	class flight_timer_scoreboard;
		mode_t       mode;
		logic [3:0]  minutes;
		logic [4:0]  remaining;
		logic [19:0] flight_ms;
		logic [9:0]  end_ms;
		logic [12:0] teach_ms;
		result_t     expected_q[$];
		int unsigned errors, checked, flashes, time_ups, stores;

		function new();
			mode      = MODE_IDLE;
			minutes   = '0;
			remaining = '0;
			flight_ms = '0;
			end_ms    = '0;
			teach_ms  = '0;
		endfunction

		// Register write reloads the working duration as well
		function void load_minutes(input logic [3:0] value);
			minutes = value;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function int unsigned sat_sum(input int unsigned a, input int unsigned b,
				input int unsigned top);
			return (a + b > top) ? top : a + b;
		endfunction

		function void note_call(input call_t c);
			result_t     r;
			int unsigned done;
			int unsigned left;
			int unsigned dwell;
			r = '0;
			// all millisecond counters run in every mode
			flight_ms = 20'(sat_sum(flight_ms, c.ms_elapsed, FLIGHT_MS_TOP));
			end_ms    = 10'(sat_sum(end_ms, c.ms_elapsed, END_MS_MAX));
			teach_ms  = 13'(sat_sum(teach_ms, c.ms_elapsed, TEACH_MS_MAX));

			if (c.button_event == EV_TEACH) begin
				mode     = MODE_TEACH;
				teach_ms = '0;
				minutes  = '0;
			end else if (c.button_event == EV_OTHER) begin
				mode = MODE_IDLE;
			end

			case (mode)
				MODE_IDLE: begin
					if (c.button_event == EV_MAIN && !c.teach_active) begin
						remaining = 5'(minutes) + 5'd1;
						mode      = MODE_COUNT;
						flight_ms = '0;
						end_ms    = '0;
					end
				end
				MODE_COUNT: begin
					if (c.button_event == EV_MAIN) begin
						mode = MODE_IDLE;
					end else begin
						done = flight_ms / MS_PER_MIN;
						if (done < minutes) begin
							left = minutes - done;
							if (remaining != left) begin
								remaining     = 5'(left);
								r.flash_valid  = 1'b1;
								r.flash_count  = 4'(left);
								r.flash_on_ms  = FLASH_LONG_MS;
								r.flash_off_ms = FLASH_LONG_MS;
							end
						end else begin
							r.time_up = 1'b1;
							if (end_ms >= END_FLASH_PERIOD) begin
								end_ms         = '0;
								r.flash_valid  = 1'b1;
								r.flash_count  = 4'd1;
								r.flash_on_ms  = FLASH_SHORT_MS;
								r.flash_off_ms = FLASH_SHORT_MS;
							end
						end
					end
				end
				MODE_TEACH: begin
					dwell = 1000 + 400 * minutes;
					if (c.button_event == EV_MAIN) begin
						mode = MODE_STORE;
					end else if (teach_ms >= dwell) begin
						teach_ms       = '0;
						minutes        = (minutes < TEACH_TOP_MIN) ? minutes + 4'd1 : 4'd1;
						r.flash_valid  = 1'b1;
						r.flash_count  = minutes;
						r.flash_on_ms  = FLASH_SHORT_MS;
						r.flash_off_ms = FLASH_SHORT_MS;
					end
				end
				default: begin
					r.store_valid   = 1'b1;
					r.store_minutes = minutes;
					mode            = MODE_IDLE;
				end
			endcase

			flashes  += r.flash_valid;
			time_ups += r.time_up;
			stores   += r.store_valid;
			expected_q.push_back(r);
		endfunction

		function void compare_field(input string field, input logic [8:0] want,
				input logic [8:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d (result %0d)", field, want, got, checked);
				errors++;
			end
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("result transaction with no call waiting: %p", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("time_up", 9'(want.time_up), 9'(got.time_up));
			compare_field("flash_valid", 9'(want.flash_valid), 9'(got.flash_valid));
			compare_field("flash_count", 9'(want.flash_count), 9'(got.flash_count));
			compare_field("flash_on_ms", want.flash_on_ms, got.flash_on_ms);
			compare_field("flash_off_ms", want.flash_off_ms, got.flash_off_ms);
			compare_field("store_valid", 9'(want.store_valid), 9'(got.store_valid));
			compare_field("store_minutes", 9'(want.store_minutes), 9'(got.store_minutes));
			checked++;
		endfunction
	endclass

	// Clock, reset and DUT-facing signals; the ones driven here are known from time zero
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       call_valid   = 1'b0;
	logic       call_ready;
	call_t      call         = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	result_t    result;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_data     = '0;

	flight_timer_scoreboard scoreboard = new();

	int unsigned send_idle_pct = 0;  // chance of a gap cycle before each call
	int unsigned stall_pct     = 0;  // chance of result_ready low in a cycle
	int unsigned calls_sent    = 0;
	int unsigned cfg_writes    = 0;
	int unsigned cycles        = 0;

	flight_countdown_teach_timer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.call_valid   (call_valid),
		.call_ready   (call_ready),
		.call         (call),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("flight_countdown_teach_timer_core verification failed");
			$finish;
		end
	end

	// Result side: values read here are the ones the DUT saw at this edge, since our
	// own updates land in the NBA region afterwards.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			scoreboard.check_result(result);
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic call_t make_call(input logic [1:0] ev, input logic lock,
			input logic [9:0] ms);
		call_t c;
		c.button_event = ev;
		c.teach_active = lock;
		c.ms_elapsed   = ms;
		return c;
	endfunction

	// Mostly long steps so the minute counters actually advance
	function automatic logic [9:0] pick_ms();
		if ($urandom_range(99) < 80)
			return 10'($urandom_range(1023, 500));
		return 10'($urandom_range(1023));
	endfunction

	// One call transaction. Valid is left high after acceptance; the next call either
	// reloads it or opens a gap, so each edge sees at most one update of call_valid.
	task automatic drive_call(input call_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			call_valid <= 1'b0;
			@(posedge clk);
		end
		call       <= c;
		call_valid <= 1'b1;
		@(posedge clk);
		while (!call_ready)
			@(posedge clk);
		scoreboard.note_call(c);
		calls_sent++;
	endtask

	task automatic write_flight_minutes(input logic [3:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		scoreboard.load_minutes(value);
		cfg_writes++;
	endtask

	// Wait for every outstanding result, then let the pipeline settle
	task automatic drain_results();
		call_valid <= 1'b0;
		while (scoreboard.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Countdown sequence: force idle (or teach a short duration first so that the
	// countdown can reach time-up), start, let time run, then stop or cancel.
	// The running span is capped by the calls left in the phase.
	task automatic countdown_run(input int unsigned budget);
		int unsigned span;
		if ($urandom_range(1)) begin
			drive_call(make_call(EV_TEACH, 1'($urandom_range(1)), pick_ms()));
			repeat ($urandom_range(3, 1))
				drive_call(make_call(EV_NONE, 1'b0, 10'($urandom_range(1023, 400))));
			drive_call(make_call(EV_MAIN, 1'b0, pick_ms()));
			drive_call(make_call(EV_NONE, 1'($urandom_range(1)), pick_ms()));
		end else begin
			drive_call(make_call(EV_OTHER, 1'($urandom_range(1)), pick_ms()));
		end
		// a locked start press must be ignored
		if ($urandom_range(3) == 0)
			drive_call(make_call(EV_MAIN, 1'b1, pick_ms()));
		drive_call(make_call(EV_MAIN, 1'b0, pick_ms()));
		span = $urandom_range(140, 20);
		if (span > budget)
			span = budget;
		repeat (span)
			drive_call(make_call(EV_NONE, 1'($urandom_range(3) == 0), pick_ms()));
		drive_call(make_call($urandom_range(1) ? EV_MAIN : EV_OTHER,
			1'($urandom_range(1)), pick_ms()));
	endtask

	// Teach sequence: step the minutes (long runs wrap past ten), then usually store
	task automatic teach_run(input int unsigned budget);
		int unsigned span;
		int unsigned ending;
		drive_call(make_call(EV_TEACH, 1'($urandom_range(1)), pick_ms()));
		span = $urandom_range(60, 5);
		if (span > budget)
			span = budget;
		repeat (span)
			drive_call(make_call(EV_NONE, 1'($urandom_range(1)), pick_ms()));
		ending = $urandom_range(99);
		if (ending < 85)
			drive_call(make_call(EV_MAIN, 1'($urandom_range(1)), pick_ms()));
		if (ending < 70)
			drive_call(make_call($urandom_range(1) ? EV_MAIN : EV_NONE,
				1'($urandom_range(1)), pick_ms()));
		else if (ending < 85)
			drive_call(make_call(EV_OTHER, 1'($urandom_range(1)), pick_ms()));
	endtask

	task automatic random_calls(input int unsigned quota);
		int unsigned target;
		int unsigned pick;
		target = calls_sent + quota;
		while (calls_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 45)
				countdown_run(target - calls_sent);
			else if (pick < 85)
				teach_run(target - calls_sent);
			else
				repeat ($urandom_range(15, 5))
					drive_call(make_call(2'($urandom_range(3)), 1'($urandom_range(1)),
						10'($urandom_range(1023))));
		end
	endtask

	int unsigned phase_idle[PHASES]  = '{0, 72, 0, 7};
	int unsigned phase_stall[PHASES] = '{0, 0, 72, 7};
	logic [3:0]  phase_cfg[PHASES];

	initial begin
		phase_cfg = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(14, 2))};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed calls with a zero duration, no idling on either side
		write_flight_minutes(4'd0);
		drive_call(make_call(EV_NONE,  1'b0, 10'd0));
		drive_call(make_call(EV_MAIN,  1'b1, 10'd1023)); // locked start ignored
		drive_call(make_call(EV_MAIN,  1'b0, 10'd0));    // countdown of zero minutes
		drive_call(make_call(EV_NONE,  1'b1, 10'd0));    // time up at once, no flash yet
		drive_call(make_call(EV_NONE,  1'b0, 10'd1023)); // end flash
		drive_call(make_call(EV_MAIN,  1'b0, 10'd5));    // stop, no flash
		drive_call(make_call(EV_TEACH, 1'b0, 10'd1023)); // teach from idle, no step yet
		drive_call(make_call(EV_NONE,  1'b0, 10'd1000)); // exactly on the dwell: one minute
		drive_call(make_call(EV_NONE,  1'b0, 10'd1023));
		drive_call(make_call(EV_NONE,  1'b0, 10'd500));  // two minutes
		drive_call(make_call(EV_TEACH, 1'b1, 10'd700));  // teach press while teaching
		drive_call(make_call(EV_NONE,  1'b0, 10'd1023));
		drive_call(make_call(EV_MAIN,  1'b0, 10'd0));    // into store
		drive_call(make_call(EV_OTHER, 1'b0, 10'd0));    // other press cancels the write
		drive_call(make_call(EV_TEACH, 1'b0, 10'd0));
		drive_call(make_call(EV_NONE,  1'b0, 10'd1023));
		drive_call(make_call(EV_MAIN,  1'b1, 10'd12));   // into store
		drive_call(make_call(EV_TEACH, 1'b0, 10'd3));    // teach press in store
		drive_call(make_call(EV_MAIN,  1'b0, 10'd0));
		drive_call(make_call(EV_NONE,  1'b0, 10'd7));    // write of zero minutes
		drive_call(make_call(EV_MAIN,  1'b0, 10'd1023));
		drive_call(make_call(EV_TEACH, 1'b0, 10'd1023)); // teach press in countdown
		drive_call(make_call(EV_OTHER, 1'b1, 10'd512));  // other press in teach
		drive_call(make_call(EV_MAIN,  1'b0, 10'd0));
		drive_call(make_call(EV_OTHER, 1'b0, 10'd0));    // other press in countdown

		// Random phases: each starts with a fresh duration and its own idling mix
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			write_flight_minutes(phase_cfg[p]);
			send_idle_pct = phase_idle[p];
			stall_pct     = phase_stall[p];
			random_calls(RANDOM_CALLS / PHASES);
		end
		drain_results();

		$display("Run: %0d calls, %0d results checked, %0d duration writes, four idling mixes.",
			calls_sent, scoreboard.checked, cfg_writes);
		$display("Seen: %0d flash requests, %0d time-up results, %0d store writes.",
			scoreboard.flashes, scoreboard.time_ups, scoreboard.stores);
		if (scoreboard.errors == 0 && scoreboard.pending() == 0)
			$display("flight_countdown_teach_timer_core verification clean");
		else
			$display("flight_countdown_teach_timer_core verification failed");
		$finish;
	end

endmodule
